### sv/led_mode_pwm_controller_assert.svh
// Assertion macros shared by the LED mode PWM controller RTL.
// No dependencies; included by led_mode_pwm_controller.sv, which carries the assertions.
`ifndef LED_MODE_PWM_CONTROLLER_ASSERT_SVH
`define LED_MODE_PWM_CONTROLLER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LMPC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define LMPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

### sv/lmpc_pkg.sv
// Package of the LED mode PWM controller: widths, mode and register codes,
// and the breathing sine table built at elaboration. No dependencies.
package lmpc_pkg;

    localparam int SINE_BITS    = 8;
    localparam int SINE_ENTRIES = 1 << SINE_BITS;
    localparam int LEVEL_W      = 8;
    localparam int STEP_W       = 15;
    localparam int WORD_W       = 16;
    localparam int PROD_W       = LEVEL_W + WORD_W;
    localparam int CFG_IDX_W    = 3;
    localparam int MODE_W       = 2;

    localparam logic [LEVEL_W-1:0] LEVEL_FULL    = 8'd255;
    localparam logic [LEVEL_W-1:0] LEVEL_MID     = 8'd128;
    localparam logic [WORD_W-1:0]  PWM_TOP_MAX   = 16'd65534;
    localparam logic [WORD_W-1:0]  PWM_TOP_RESET = 16'd999;

    // Q30 fixed point constants for the table build.
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    typedef enum logic [MODE_W-1:0] {
        MODE_OFF     = 2'd0,
        MODE_ON      = 2'd1,
        MODE_BLINK   = 2'd2,
        MODE_BREATHE = 2'd3
    } t_led_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LED_MODE   = 3'd0,
        REG_STEADY     = 3'd1,
        REG_BLINK_HALF = 3'd2,
        REG_PHASE_STEP = 3'd3,
        REG_PWM_TOP    = 3'd4
    } t_cfg_reg;

    typedef logic [SINE_ENTRIES-1:0][LEVEL_W-1:0] t_sine_table;

    // Magnitude trunc(127 * sin(r / SINE_ENTRIES * pi / 2)) for r in the first
    // quadrant, from a Taylor series up to the eleventh power in Q30.
    function automatic logic [LEVEL_W-1:0] quarter_sine127(logic [63:0] r);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        if (r == 64'd0) begin
            return '0;
        end
        if (r >= 64'(SINE_ENTRIES)) begin
            return 8'd127;
        end
        x    = (r * HALF_PI_Q30) >> SINE_BITS;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        term = ((term * x2) / 6) >> 30;
        sum  = sum - term;
        term = ((term * x2) / 20) >> 30;
        sum  = sum + term;
        term = ((term * x2) / 42) >> 30;
        sum  = sum - term;
        term = ((term * x2) / 72) >> 30;
        sum  = sum + term;
        term = ((term * x2) / 110) >> 30;
        sum  = sum - term;
        if (sum > ONE_Q30) begin
            sum = ONE_Q30;
        end
        return LEVEL_W'((64'd127 * sum) >> 30);
    endfunction

    // Full turn of 128 + trunc(127 * sin), folded from the first quadrant.
    function automatic t_sine_table build_sine_table();
        t_sine_table          tbl;
        logic [63:0]          pos;
        logic [63:0]          r;
        logic [1:0]           quad;
        logic [LEVEL_W-1:0]   mag;
        for (int i = 0; i < SINE_ENTRIES; i++) begin
            pos  = 64'(4 * i);
            quad = 2'(pos >> SINE_BITS);
            r    = pos & 64'(SINE_ENTRIES - 1);
            if (quad[0]) begin
                r = 64'(SINE_ENTRIES) - r;
            end
            mag    = quarter_sine127(r);
            tbl[i] = quad[1] ? (LEVEL_MID - mag) : (LEVEL_MID + mag);
        end
        return tbl;
    endfunction

    localparam t_sine_table SINE_TABLE = build_sine_table();

endpackage

### sv/lmpc_div255.sv
// Exact division of the brightness-period product by 255, without a divider.
// Depends on lmpc_pkg for the widths.
module lmpc_div255 (
    input  logic [lmpc_pkg::PROD_W-1:0] i_prod,
    output logic [lmpc_pkg::WORD_W-1:0] o_quot
);
    import lmpc_pkg::*;

    localparam int EST_W = WORD_W + 1;
    localparam int REM_W = PROD_W + 1;

    logic [EST_W-1:0] q_est;
    logic [REM_W-1:0] q_times_255;
    logic [REM_W-1:0] rem_full;
    logic [9:0]       rem;
    logic [1:0]       fix;
    logic [EST_W-1:0] q_sum;

    // 1/255 = 1/256 + 1/256^2 + ..., so the shifted sum falls short of the
    // true quotient by at most three; the remainder says by how much.
    always_comb begin
        q_est       = EST_W'(i_prod[PROD_W-1:8]) + EST_W'(i_prod[PROD_W-1:16]);
        q_times_255 = (REM_W'(q_est) << 8) - REM_W'(q_est);
        rem_full    = REM_W'(i_prod) - q_times_255;
        rem         = rem_full[9:0];
        fix         = 2'((rem >= 10'd255) ? 1 : 0) + 2'((rem >= 10'd510) ? 1 : 0)
                    + 2'((rem >= 10'd765) ? 1 : 0);
        q_sum       = q_est + EST_W'(fix);
        o_quot      = q_sum[WORD_W-1:0];
    end

endmodule

### sv/led_mode_pwm_controller.sv
// Top level of the LED mode PWM controller: configuration registers, mode
// state, a three-stage result pipeline. Depends on lmpc_pkg, lmpc_div255 and
// the assertion macros in led_mode_pwm_controller_assert.svh.
//
//  Channel   Handshake                    Word
//  --------  ---------------------------  ------------------------------------
//  input     i_valid / o_ready            i_tick
//  result    o_valid / i_ready            o_pwm_compare, o_pwm_enable,
//                                         o_level_now
//  config    i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// One input word is taken every cycle while o_ready is high; the mode step and
// level, the 8x16 multiply and the divide by 255 are each registered in turn.
// A stalled result channel fills the three stages before o_ready drops, so
// a waiting result never blocks the stage behind it while space remains.
// Reset (i_rst_n low at a rising edge) empties the pipeline, clears the mode
// state and loads the register reset values. The config port never stalls.
module led_mode_pwm_controller #(
    parameter int PHASE_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input channel.
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_tick,
    // Result channel.
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [lmpc_pkg::WORD_W-1:0]       o_pwm_compare,
    output logic                              o_pwm_enable,
    output logic [lmpc_pkg::LEVEL_W-1:0]      o_level_now,
    // Configuration write channel.
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lmpc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lmpc_pkg::WORD_W-1:0]       i_cfg_data
);
    import lmpc_pkg::*;

    `include "led_mode_pwm_controller_assert.svh"

    // The sum is wide enough for both the phase and the step, and is then
    // wrapped to one full turn of the phase.
    localparam int SUM_W = (PHASE_BITS > STEP_W) ? PHASE_BITS : STEP_W;

    // Configuration registers.
    t_led_mode           r_led_mode;
    logic [LEVEL_W-1:0]  r_steady;
    logic [WORD_W-1:0]   r_blink_half;
    logic [STEP_W-1:0]   r_phase_step;
    logic [WORD_W-1:0]   r_pwm_top;

    // Mode state.
    logic [PHASE_BITS-1:0] r_phase;
    logic                  r_blink_off;
    logic [WORD_W-1:0]     r_blink_count;

    logic [PHASE_BITS-1:0] n_phase;
    logic                  n_blink_off;
    logic [WORD_W-1:0]     n_blink_count;
    logic [LEVEL_W-1:0]    n_level;
    logic                  n_enable;

    logic [SUM_W-1:0]      phase_sum;
    logic [WORD_W-1:0]     blink_limit;
    logic [WORD_W-1:0]     count_inc;

    // Pipeline registers.
    logic                  r_s1_valid;
    logic [LEVEL_W-1:0]    r_s1_level;
    logic                  r_s1_enable;
    logic                  r_s2_valid;
    logic [PROD_W-1:0]     r_s2_prod;
    logic [LEVEL_W-1:0]    r_s2_level;
    logic                  r_s2_enable;
    logic                  r_out_valid;
    logic [WORD_W-1:0]     r_out_compare;
    logic                  r_out_enable;
    logic [LEVEL_W-1:0]    r_out_level;

    logic                  out_space;
    logic                  s2_space;
    logic                  s1_space;
    logic                  in_accept;
    logic                  cfg_write;
    logic [LEVEL_W-1:0]    s1_inv_level;
    logic [WORD_W-1:0]     top_plus_one;
    logic [WORD_W-1:0]     div_quot;

    // A stage may load when it is empty or when its word moves on this cycle.
    assign out_space = !r_out_valid || i_ready;
    assign s2_space  = !r_s2_valid || out_space;
    assign s1_space  = !r_s1_valid || s2_space;
    assign o_ready   = s1_space;
    assign in_accept = i_valid && o_ready;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid;

    // Mode step for the word being accepted. Each mode only moves its own
    // state, so blink and breathe state rest in the other modes.
    always_comb begin
        n_phase       = r_phase;
        n_blink_off   = r_blink_off;
        n_blink_count = r_blink_count;
        n_level       = '0;
        n_enable      = 1'b0;
        phase_sum     = SUM_W'(r_phase) + SUM_W'(r_phase_step);
        blink_limit   = (r_blink_half == '0) ? WORD_W'(1) : r_blink_half;
        count_inc     = r_blink_count + WORD_W'(1);
        unique case (r_led_mode)
            MODE_ON: begin
                n_level  = r_steady;
                n_enable = 1'b1;
            end
            MODE_BLINK: begin
                if (i_tick) begin
                    if (count_inc >= blink_limit) begin
                        n_blink_count = '0;
                        n_blink_off   = !r_blink_off;
                    end else begin
                        n_blink_count = count_inc;
                    end
                end
                n_level  = r_steady;
                n_enable = !n_blink_off;
            end
            MODE_BREATHE: begin
                if (i_tick) begin
                    n_phase = phase_sum[PHASE_BITS-1:0];
                end
                // The table index is the top bits of the phase.
                n_level  = SINE_TABLE[n_phase[PHASE_BITS-1 -: SINE_BITS]];
                n_enable = 1'b1;
            end
            MODE_OFF: begin
                n_level  = '0;
                n_enable = 1'b0;
            end
            default: begin
                n_level  = '0;
                n_enable = 1'b0;
            end
        endcase
    end

    // Configuration and mode state. A mode write restarts the breathing
    // phase and the blink count but keeps the blink half in progress.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_mode    <= MODE_OFF;
            r_steady      <= '0;
            r_blink_half  <= WORD_W'(1);
            r_phase_step  <= '0;
            r_pwm_top     <= PWM_TOP_RESET;
            r_phase       <= '0;
            r_blink_off   <= 1'b0;
            r_blink_count <= '0;
        end else begin
            if (in_accept) begin
                r_phase       <= n_phase;
                r_blink_off   <= n_blink_off;
                r_blink_count <= n_blink_count;
            end
            if (cfg_write) begin
                unique case (i_cfg_index)
                    REG_LED_MODE: begin
                        r_led_mode    <= t_led_mode'(i_cfg_data[MODE_W-1:0]);
                        r_phase       <= '0;
                        r_blink_count <= '0;
                    end
                    REG_STEADY: begin
                        r_steady <= i_cfg_data[LEVEL_W-1:0];
                    end
                    REG_BLINK_HALF: begin
                        r_blink_half <= i_cfg_data;
                    end
                    REG_PHASE_STEP: begin
                        r_phase_step <= i_cfg_data[STEP_W-1:0];
                    end
                    REG_PWM_TOP: begin
                        // Keep the scaled compare value within 16 bits.
                        r_pwm_top <= (i_cfg_data > PWM_TOP_MAX) ? PWM_TOP_MAX : i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Valid bits of the three stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_space) begin
                r_s1_valid <= in_accept;
            end
            if (s2_space) begin
                r_s2_valid <= r_s1_valid;
            end
            if (out_space) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    // The compare value is the inverted brightness scaled to the period:
    // (255 - level) * (pwm_top + 1) / 255. pwm_top is at most 65534, so
    // pwm_top + 1 still fits 16 bits.
    assign s1_inv_level = LEVEL_FULL - r_s1_level;
    assign top_plus_one = r_pwm_top + WORD_W'(1);

    lmpc_div255 u_div255 (
        .i_prod (r_s2_prod),
        .o_quot (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_level  <= n_level;
            r_s1_enable <= n_enable;
        end
        if (s2_space) begin
            r_s2_prod   <= PROD_W'(s1_inv_level) * PROD_W'(top_plus_one);
            r_s2_level  <= r_s1_level;
            r_s2_enable <= r_s1_enable;
        end
        if (out_space) begin
            r_out_compare <= div_quot;
            r_out_level   <= r_s2_level;
            r_out_enable  <= r_s2_enable;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_pwm_compare = r_out_compare;
    assign o_pwm_enable  = r_out_enable;
    assign o_level_now   = r_out_level;

    // Input back-pressure only appears once every stage holds a word.
    `LMPC_ASSERT_IMP(a_full_when_stalled, i_clk, i_rst_n, !o_ready,
        r_s1_valid && r_s2_valid && r_out_valid, "input stalled with a free stage")

    // Full brightness leaves nothing of the inverted compare value.
    `LMPC_ASSERT_IMP(a_full_level_zero_compare, i_clk, i_rst_n,
        o_valid && (o_level_now == LEVEL_FULL), o_pwm_compare == '0,
        "full brightness with a nonzero compare value")

    // The breathing phase rests outside breathe mode unless reconfigured.
    `LMPC_ASSERT_NEXT(a_phase_rests, i_clk, i_rst_n,
        (r_led_mode != MODE_BREATHE) && !cfg_write, $stable(r_phase),
        "breathing phase moved outside breathe mode")

endmodule

### tb/led_mode_pwm_controller_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for led_mode_pwm_controller: directed mode tests, then random
// register settings with random tick words. It depends on the RTL and on lmpc_pkg.
module led_mode_pwm_controller_test;

    localparam int LUT_SIZE     = lmpc_pkg::SINE_ENTRIES;
    localparam int PHASE_W      = 16;
    localparam int IDX_W        = lmpc_pkg::CFG_IDX_W;
    localparam int RANDOM_WORDS = 1530;
    localparam int IDLE_PCT     = 23;
    localparam int TICK_PCT     = 80;
    localparam int CALM_PHASE   = 3;
    localparam int CALM_WORDS   = 250;
    localparam int DRAIN_CYCLES = 8;
    localparam int TIMEOUT_NS   = 12 * 200000;

    // Q30 fixed point: pi/2 and one.
    localparam longint unsigned Q30_HALF_PI = 64'd1686629713;
    localparam longint unsigned Q30_ONE     = 64'd1073741824;
    localparam longint unsigned SINE_AMPL   = 64'd127;
    localparam logic [7:0]      SINE_MID    = 8'd128;
    localparam logic [7:0]      LEVEL_MAX   = 8'd255;
    localparam logic [15:0]     TOP_CEILING = 16'd65534;
    localparam logic [15:0]     TOP_OVERSIZE = 16'hFFFF;

    // Register indexes past the last real register; writes to them are dropped.
    localparam logic [IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;
    localparam logic [IDX_W-1:0] CFG_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [15:0] compare;
        logic        enable;
        logic [7:0]  level;
    } t_pwm_word;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_valid = 1'b0;
    logic                                o_ready;
    logic                                i_tick = 1'b0;
    logic                                o_valid;
    logic                                i_ready = 1'b0;
    logic [lmpc_pkg::WORD_W-1:0]         o_pwm_compare;
    logic                                o_pwm_enable;
    logic [lmpc_pkg::LEVEL_W-1:0]        o_level_now;
    logic                                i_cfg_valid = 1'b0;
    logic                                o_cfg_ready;
    logic [IDX_W-1:0]                    i_cfg_index = '0;
    logic [lmpc_pkg::WORD_W-1:0]         i_cfg_data = '0;

    // When low, both channels run without random idling.
    logic gaps_on = 1'b1;

    // Own copy of the controller registers, at their reset values.
    lmpc_pkg::t_led_mode led_mode_q   = lmpc_pkg::MODE_OFF;
    logic [7:0]          steady_q     = 8'd0;
    logic [15:0]         blink_half_q = 16'd1;
    logic [14:0]         step_q       = 15'd0;
    logic [15:0]         top_q        = 16'd999;

    // Own copy of the mode state.
    logic [PHASE_W-1:0]  phase_q       = '0;
    logic                blink_off_q   = 1'b0;
    logic [15:0]         blink_count_q = '0;

    logic [7:0] sine_lut [LUT_SIZE];

    t_pwm_word pwm_words_due[$];
    int        words_sent = 0;
    int        words_checked = 0;
    int        mismatch_count = 0;

    always #6 i_clk = ~i_clk;

    led_mode_pwm_controller u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_tick        (i_tick),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_pwm_compare (o_pwm_compare),
        .o_pwm_enable  (o_pwm_enable),
        .o_level_now   (o_level_now),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // trunc(127 * sin(r / LUT_SIZE * pi / 2)) for r in the first quadrant. The sine is an
    // odd Taylor series up to the eleventh power, each term derived from the one before
    // and truncated to Q30 as it goes.
    function automatic logic [7:0] quarter_sine_mag(input longint unsigned r);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned acc;
        if (r == 0) begin
            return 8'd0;
        end
        if (r >= LUT_SIZE) begin
            return 8'(SINE_AMPL);
        end
        x    = (r * Q30_HALF_PI) / LUT_SIZE;
        x2   = (x * x) >> 30;
        term = x;
        acc  = x;
        for (int k = 1; k <= 5; k++) begin
            term = ((term * x2) / longint'((2 * k) * (2 * k + 1))) >> 30;
            if (k % 2 == 1) begin
                acc = acc - term;
            end else begin
                acc = acc + term;
            end
        end
        if (acc > Q30_ONE) begin
            acc = Q30_ONE;
        end
        return 8'((SINE_AMPL * acc) >> 30);
    endfunction

    // The full turn is folded onto the first quadrant: odd quadrants run backward and
    // the second half of the turn sits below mid scale.
    initial begin : build_sine_lut
        longint unsigned pos;
        longint unsigned quad;
        longint unsigned r;
        logic [7:0]      mag;
        for (int i = 0; i < LUT_SIZE; i++) begin
            pos  = 4 * i;
            quad = pos / LUT_SIZE;
            r    = pos % LUT_SIZE;
            if (quad % 2 == 1) begin
                r = LUT_SIZE - r;
            end
            mag = quarter_sine_mag(r);
            sine_lut[i] = (quad >= 2) ? (SINE_MID - mag) : (SINE_MID + mag);
        end
    end

    // Applies one accepted register write to the local copy. Writing the mode restarts
    // the breathing phase and the blink count but keeps the blink half the LED is in.
    function automatic void apply_reg_write(input logic [IDX_W-1:0] reg_index,
                                            input logic [15:0] reg_data);
        case (reg_index)
            lmpc_pkg::REG_LED_MODE: begin
                led_mode_q    = lmpc_pkg::t_led_mode'(reg_data[1:0]);
                phase_q       = '0;
                blink_count_q = '0;
            end
            lmpc_pkg::REG_STEADY:     steady_q     = reg_data[7:0];
            lmpc_pkg::REG_BLINK_HALF: blink_half_q = reg_data;
            lmpc_pkg::REG_PHASE_STEP: step_q       = reg_data[14:0];
            lmpc_pkg::REG_PWM_TOP:    top_q = (reg_data > TOP_CEILING) ? TOP_CEILING : reg_data;
            default: ;
        endcase
    endfunction

    // Advances the mode state by one input word and returns the PWM word it yields.
    function automatic t_pwm_word next_pwm_word(input logic tick);
        t_pwm_word   w;
        logic [15:0] limit;
        logic [31:0] scaled;
        w.level  = '0;
        w.enable = 1'b0;
        case (led_mode_q)
            lmpc_pkg::MODE_ON: begin
                w.level  = steady_q;
                w.enable = 1'b1;
            end
            lmpc_pkg::MODE_BLINK: begin
                if (tick) begin
                    // An interval of zero behaves like one tick.
                    limit = (blink_half_q == '0) ? 16'd1 : blink_half_q;
                    blink_count_q = blink_count_q + 16'd1;
                    if (blink_count_q >= limit) begin
                        blink_count_q = '0;
                        blink_off_q   = ~blink_off_q;
                    end
                end
                w.level  = steady_q;
                w.enable = ~blink_off_q;
            end
            lmpc_pkg::MODE_BREATHE: begin
                if (tick) begin
                    phase_q = phase_q + PHASE_W'(step_q);
                end
                w.level  = sine_lut[phase_q[PHASE_W-1 -: lmpc_pkg::SINE_BITS]];
                w.enable = 1'b1;
            end
            default: ;
        endcase
        // The PWM is active low, so the compare value grows as the level drops.
        scaled = (32'(LEVEL_MAX - w.level) * (32'(top_q) + 32'd1)) / 32'(LEVEL_MAX);
        w.compare = scaled[15:0];
        return w;
    endfunction

    // Handshakes are sampled right after the rising edge, before any register of the
    // block or any driven input has taken its new value, so all reads see the values
    // that the edge itself saw.
    always @(posedge i_clk) begin : check_results
        t_pwm_word want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                apply_reg_write(i_cfg_index, i_cfg_data);
            end
            if (i_valid && o_ready) begin
                pwm_words_due.push_back(next_pwm_word(i_tick));
            end
            if (o_valid && i_ready) begin
                if (pwm_words_due.size() == 0) begin
                    $display("%0t ns: result word with none expected: compare %0d, enable %0d, level %0d",
                             $time, o_pwm_compare, o_pwm_enable, o_level_now);
                    mismatch_count++;
                end else begin
                    want = pwm_words_due.pop_front();
                    if (o_pwm_compare !== want.compare) begin
                        $display("%0t ns: pwm_compare expected %0d, got %0d",
                                 $time, want.compare, o_pwm_compare);
                        mismatch_count++;
                    end
                    if (o_pwm_enable !== want.enable) begin
                        $display("%0t ns: pwm_enable expected %0d, got %0d",
                                 $time, want.enable, o_pwm_enable);
                        mismatch_count++;
                    end
                    if (o_level_now !== want.level) begin
                        $display("%0t ns: level_now expected %0d, got %0d",
                                 $time, want.level, o_level_now);
                        mismatch_count++;
                    end
                    words_checked++;
                end
            end
        end
    end

    // The result side stalls at random, except during the calm stretch.
    always @(posedge i_clk) begin
        if (gaps_on) begin
            i_ready <= ($urandom_range(99) >= IDLE_PCT);
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Sends one tick word. Valid is not lowered after the handshake; the next call
    // either keeps it high for a new word or drops it for an idle gap first, so valid
    // never gets two assignments in one time step.
    task automatic send_tick(input logic tick_bit);
        if (gaps_on) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_tick  <= tick_bit;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        words_sent++;
    endtask

    // Stops the input side and waits until every result word has come back, so the
    // block is idle for a register write.
    task automatic drain_words();
        i_valid <= 1'b0;
        while (words_checked < words_sent) begin
            @(posedge i_clk);
        end
    endtask

    // Like send_tick, the write leaves valid high; release_cfg lowers it after the
    // last write of a group.
    task automatic write_reg(input logic [IDX_W-1:0] reg_index, input logic [15:0] reg_data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= reg_index;
        i_cfg_data  <= reg_data;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
    endtask

    task automatic release_cfg();
        i_cfg_valid <= 1'b0;
    endtask

    // Straight out of reset the block is off with a period of 1000 counts.
    task automatic test_reset_values();
        send_tick(1'b0);
        send_tick(1'b1);
    endtask

    // Steady mode at full and zero brightness and at mid scale, across the smallest,
    // the saturated and the default PWM period. The first mode write carries junk in
    // its upper bits, which must be ignored.
    task automatic test_steady_levels();
        drain_words();
        write_reg(lmpc_pkg::REG_LED_MODE, {14'h3FFF, lmpc_pkg::MODE_ON});
        write_reg(lmpc_pkg::REG_STEADY, 16'h00FF);
        write_reg(lmpc_pkg::REG_PWM_TOP, 16'h0000);
        release_cfg();
        send_tick(1'b1);
        drain_words();
        write_reg(lmpc_pkg::REG_STEADY, 16'hFF00);
        write_reg(lmpc_pkg::REG_PWM_TOP, TOP_OVERSIZE);
        release_cfg();
        send_tick(1'b0);
        drain_words();
        write_reg(lmpc_pkg::REG_STEADY, 16'h0080);
        write_reg(lmpc_pkg::REG_PWM_TOP, 16'd999);
        release_cfg();
        send_tick(1'b1);
    endtask

    // A zero interval toggles on every tick, refresh words leave the state alone, and
    // rewriting the mode restarts the count while the LED stays in its current half.
    task automatic test_blink_toggle();
        drain_words();
        write_reg(lmpc_pkg::REG_BLINK_HALF, 16'd0);
        write_reg(lmpc_pkg::REG_STEADY, 16'd77);
        write_reg(lmpc_pkg::REG_LED_MODE, {14'h0000, lmpc_pkg::MODE_BLINK});
        release_cfg();
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b1);
        drain_words();
        write_reg(lmpc_pkg::REG_BLINK_HALF, 16'd3);
        write_reg(lmpc_pkg::REG_LED_MODE, {14'h0000, lmpc_pkg::MODE_BLINK});
        release_cfg();
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
    endtask

    // The largest step, written with its unused top bit set, and then a quarter turn
    // per tick that lands just short of the trough and of the midpoint of the sine.
    task automatic test_breathe_sweep();
        drain_words();
        write_reg(lmpc_pkg::REG_PHASE_STEP, 16'hFFFF);
        write_reg(lmpc_pkg::REG_LED_MODE, {14'h0000, lmpc_pkg::MODE_BREATHE});
        release_cfg();
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b1);
        drain_words();
        write_reg(lmpc_pkg::REG_PHASE_STEP, 16'h4000);
        release_cfg();
        send_tick(1'b1);
        send_tick(1'b1);
    endtask

    // A write to an index past the last register must not change anything.
    task automatic test_spare_index();
        drain_words();
        write_reg(CFG_SPARE_LAST, 16'hFFFF);
        release_cfg();
        send_tick(1'b0);
    endtask

    // Phases of random register writes, each followed by a burst of mostly tick words.
    // One long phase runs with no idling on either side.
    task automatic test_random_mix();
        int   words_left;
        int   burst;
        int   phase_no;
        logic wrote;
        words_left = RANDOM_WORDS;
        phase_no   = 0;
        while (words_left > 0) begin
            gaps_on <= (phase_no != CALM_PHASE);
            drain_words();
            wrote = 1'b0;
            if ($urandom_range(99) < 50) begin
                write_reg(lmpc_pkg::REG_LED_MODE, 16'($urandom));
                wrote = 1'b1;
            end
            if ($urandom_range(99) < 40) begin
                case ($urandom_range(3))
                    0:       write_reg(lmpc_pkg::REG_STEADY, 16'h0000);
                    1:       write_reg(lmpc_pkg::REG_STEADY, 16'h00FF);
                    default: write_reg(lmpc_pkg::REG_STEADY, 16'($urandom));
                endcase
                wrote = 1'b1;
            end
            if ($urandom_range(99) < 40) begin
                // Short intervals keep the blink toggling; long ones are rare.
                if ($urandom_range(9) == 0) begin
                    write_reg(lmpc_pkg::REG_BLINK_HALF, 16'($urandom));
                end else begin
                    write_reg(lmpc_pkg::REG_BLINK_HALF, 16'($urandom_range(6)));
                end
                wrote = 1'b1;
            end
            if ($urandom_range(99) < 40) begin
                case ($urandom_range(4))
                    0:       write_reg(lmpc_pkg::REG_PHASE_STEP, 16'h0000);
                    1:       write_reg(lmpc_pkg::REG_PHASE_STEP, 16'h7FFF);
                    default: write_reg(lmpc_pkg::REG_PHASE_STEP, 16'($urandom));
                endcase
                wrote = 1'b1;
            end
            if ($urandom_range(99) < 40) begin
                case ($urandom_range(5))
                    0:       write_reg(lmpc_pkg::REG_PWM_TOP, 16'h0000);
                    1:       write_reg(lmpc_pkg::REG_PWM_TOP, TOP_CEILING);
                    2:       write_reg(lmpc_pkg::REG_PWM_TOP, TOP_OVERSIZE);
                    default: write_reg(lmpc_pkg::REG_PWM_TOP, 16'($urandom));
                endcase
                wrote = 1'b1;
            end
            if ($urandom_range(99) < 15) begin
                write_reg(IDX_W'($urandom_range(CFG_SPARE_LAST, CFG_SPARE_FIRST)),
                          16'($urandom));
                wrote = 1'b1;
            end
            if (!wrote) begin
                write_reg(lmpc_pkg::REG_STEADY, 16'($urandom));
            end
            release_cfg();
            burst = (phase_no == CALM_PHASE) ? CALM_WORDS : $urandom_range(10, 60);
            if (burst > words_left) begin
                burst = words_left;
            end
            repeat (burst) begin
                send_tick($urandom_range(99) < TICK_PCT);
            end
            words_left -= burst;
            phase_no++;
        end
        gaps_on <= 1'b1;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_values();
        test_steady_levels();
        test_blink_toggle();
        test_breathe_sweep();
        test_spare_index();
        test_random_mix();
        drain_words();
        // Give any stray word time to show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pwm_words_due.size() != 0) begin
            $display("%0t ns: %0d result words never arrived", $time, pwm_words_due.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("%0t ns: run stopped, no progress", $time);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
